>>> rtl/ldac_pkg.sv
// Shared types and constants for the log-domain audio compressor.
`default_nettype none
package ldac_pkg;

   localparam int unsigned DbPerLog2Q16 = 394566;
   localparam int unsigned FloorDbMag   = 25600;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_THRESHOLD = 3'd0,
      CSR_SLOPE     = 3'd1,
      CSR_ATTACK    = 3'd2,
      CSR_RELEASE   = 3'd3,
      CSR_MAKEUP    = 3'd4
   } csr_index_type;

   typedef logic [16:0][31:0] pow_tab_type;

   // Floor square root, evaluated at elaboration for the factor table
   function automatic logic [63:0] floor_root(input logic [63:0] v);
      logic [63:0] x;
      logic [63:0] res;
      logic [63:0] b;
      x   = v;
      res = '0;
      b   = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 64'd0) begin
         if (x >= res + b) begin
            x   = x - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // Factors 2^(2^-k) in Q1.30 for k = 1..16 by a floor square-root chain; entry 0 holds 1.0
   function automatic pow_tab_type build_pow_tab();
      pow_tab_type t;
      t[0] = 32'd1073741824;
      t[1] = 32'(floor_root(64'd1 << 61));
      for (int k = 2; k <= 16; k++) t[k] = 32'(floor_root({32'd0, t[k-1]} << 30));
      return t;
   endfunction

   localparam pow_tab_type PowTab = build_pow_tab();

   function automatic logic [31:0] pow_factor(input logic [4:0] k);
      return (k <= 5'd16) ? PowTab[k] : PowTab[0];
   endfunction

endpackage
`default_nettype wire

>>> rtl/log_domain_audio_compressor.sv
// Feedforward compressor: level detect, gain smoothing and gain apply per sample.
//
// Usage: a sample enters on req_ (tdata = sample_in, tuser = channel). One result
// per transaction leaves on rsp_ (tdata = sample_out, gain_db). Registers are
// written on the csr_ channel by index, by the user only while no transaction
// is in flight; the block itself does not enforce this.
// From the accepting edge to rsp_tvalid: one normalize step, 16 log2
// squaring steps (one fraction bit each), the level, target, smoothing and
// total-gain math, 16 antilog product steps (one gain fraction bit each),
// then one scale step, one saturate step and the output register. A zero
// sample skips the squaring. One transaction is handled at a time.
// Reset returns the registers to their defaults and clears all channel gains to
// 0 dB. When the receiver stalls, the result is held in the output register; the
// next transaction is still accepted and computed, then waits in its last step
// until the held result is taken.
`default_nettype none
module log_domain_audio_compressor
   import ldac_pkg::*;
#(
   parameter int CHANNELS    = 8,
   parameter int SAMPLE_BITS = 24
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  wire [SAMPLE_BITS-1:0]  req_tdata,  // sample_in
   input  wire [2:0]              req_tuser,  // channel
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   output logic [((SAMPLE_BITS+22)/8)*8-1:0] rsp_tdata, // sample_out, gain_db, zero pad
   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  wire [2:0]              csr_index,
   input  wire [15:0]             csr_data
);
   localparam int CH_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SB = SAMPLE_BITS;
   localparam int RSP_W = ((SAMPLE_BITS + 22) / 8) * 8;

   typedef enum logic [3:0] {
      S_IDLE, S_NORM, S_SQ, S_LVL, S_TGT, S_SM1, S_SM2, S_TOT, S_EXP, S_MUL,
      S_SAT, S_OUT
   } state_type;

   state_type          state_ff;
   logic signed [14:0] thr_ff;
   logic [15:0]        slope_ff, att_ff, rel_ff;
   logic [12:0]        mkp_ff;
   logic signed [31:0] gain_ff [CHANNELS];
   logic [SB:0]        mag_ff;
   logic               neg_ff;
   logic [CH_BITS-1:0] ch_ff;
   logic [5:0]         e_ff;
   logic [4:0]         cnt_ff;
   logic [63:0]        y_ff;
   logic [15:0]        frac_ff;
   logic [31:0]        ng_ff;
   logic [31:0]        tmag_ff;
   logic [63:0]        lb_ff;
   logic [31:0]        acc_ff;
   logic [RSP_W-1:0]   out_ff;
   logic               ov_ff;

   logic [2:0]  ch_mod;
   logic [63:0] sq;
   logic [63:0] accp;
   logic [5:0]  lz;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = out_ff;

   // Fold the channel into range by repeated subtraction
   always_comb begin
      ch_mod = req_tuser;
      for (int i = 0; i < 7; i++) begin
         if (int'(ch_mod) >= CHANNELS) ch_mod = ch_mod - 3'(CHANNELS);
      end
   end

   // Squaring multiplier for the log2 steps and product multiplier for the antilog steps
   assign sq   = y_ff[31:0] * y_ff[31:0];
   assign accp = acc_ff * pow_factor(cnt_ff) + 64'd536870912;

   always_comb begin
      lz = 6'd0;
      for (int i = 0; i < SB + 1; i++) begin
         if (mag_ff[i]) lz = 6'(i);
      end
   end

   always_ff @(posedge clock) begin
      logic [63:0] lvl_tmp, neg, tot_tmp, prod, res, tp;
      logic signed [63:0] over, tot, p;
      logic [63:0] ip_sh;
      logic [15:0] coef;
      logic [63:0] mag64;
      if (reset) begin
         state_ff <= S_IDLE;
         ov_ff    <= 1'b0;
         thr_ff   <= -15'sd3072;
         slope_ff <= 16'd49152;
         att_ff   <= 16'd65400;
         rel_ff   <= 16'd65522;
         mkp_ff   <= 13'd0;
         for (int i = 0; i < CHANNELS; i++) gain_ff[i] <= 32'sd0;
      end else begin
         if (ov_ff && rsp_tready) ov_ff <= 1'b0;
         // Register writes
         if (csr_valid) begin
            unique case (csr_index)
               CSR_THRESHOLD: thr_ff   <= csr_data[14:0];
               CSR_SLOPE:     slope_ff <= csr_data;
               CSR_ATTACK:    att_ff   <= csr_data;
               CSR_RELEASE:   rel_ff   <= csr_data;
               CSR_MAKEUP:    mkp_ff   <= csr_data[12:0];
               default:       ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  neg_ff   <= req_tdata[SB-1];
                  mag_ff   <= req_tdata[SB-1] ? (SB+1)'(-{1'b1, req_tdata})
                                              : {1'b0, req_tdata};
                  ch_ff    <= CH_BITS'(ch_mod);
                  state_ff <= S_NORM;
               end
            end
            // Normalize magnitude to Q1.30
            S_NORM: begin
               e_ff     <= lz;
               y_ff     <= (lz <= 6'd30) ? (64'(mag_ff) << (6'd30 - lz))
                                         : (64'(mag_ff) >> (lz - 6'd30));
               frac_ff  <= 16'd0;
               cnt_ff   <= 5'd0;
               state_ff <= (mag_ff == '0) ? S_LVL : S_SQ;
            end
            // One log2 fraction bit per cycle
            S_SQ: begin
               tp = sq >> 30;
               if (tp[31]) begin
                  frac_ff <= {frac_ff[14:0], 1'b1};
                  y_ff    <= tp >> 1;
               end else begin
                  frac_ff <= {frac_ff[14:0], 1'b0};
                  y_ff    <= tp;
               end
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd15) state_ff <= S_LVL;
            end
            S_LVL: begin
               neg = (64'(SB - 1) << 16) - ((64'(e_ff) << 16) | 64'(frac_ff));
               lvl_tmp = (neg * 64'(DbPerLog2Q16) + 64'd8388608) >> 24;
               if (mag_ff == '0 || lvl_tmp > 64'(FloorDbMag))
                  lvl_tmp = 64'(FloorDbMag);
               y_ff     <= lvl_tmp;
               state_ff <= S_TGT;
            end
            S_TGT: begin
               over = -$signed(y_ff) - 64'(thr_ff);
               if (over > 0)
                  tmag_ff <= 32'((64'(over) * 64'(slope_ff) + 64'd32768) >> 16);
               else
                  tmag_ff <= 32'd0;
               ng_ff    <= 32'(-gain_ff[ch_ff]);
               state_ff <= S_SM1;
            end
            S_SM1: begin
               coef = ({tmag_ff, 16'd0} > 48'(ng_ff)) ? att_ff : rel_ff;
               y_ff <= 64'(coef) * 64'(ng_ff)
                     + 64'(17'h10000 - 17'(coef)) * {16'd0, tmag_ff, 16'd0}
                     + 64'd32768;
               state_ff <= S_SM2;
            end
            S_SM2: begin
               ng_ff    <= 32'(y_ff >> 16);
               gain_ff[ch_ff] <= -$signed(32'(y_ff >> 16));
               state_ff <= S_TOT;
            end
            S_TOT: begin
               tot = $signed(64'(mkp_ff) << 16) - $signed(64'(ng_ff));
               p = (tot * 64'sd713378626 + (64'sd1 <<< 61)) >>> 32;
               lb_ff    <= 64'(p) - (64'd1 << 29) + (64'd16 << 24);
               acc_ff   <= 32'd1073741824;
               cnt_ff   <= 5'd1;
               state_ff <= S_EXP;
            end
            // One antilog fraction bit per cycle
            S_EXP: begin
               if (lb_ff[24 - cnt_ff]) acc_ff <= 32'(accp >> 30);
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd16) state_ff <= S_MUL;
            end
            // Scale the magnitude by the mantissa and round
            S_MUL: begin
               mag64 = 64'(mag_ff);
               ip_sh = 64'(lb_ff[31:24]);
               over  = 64'sd30 - ($signed(ip_sh) - 64'sd16);
               if (over < 64'sd1) over = 64'sd1;
               if (over > 64'sd62) over = 64'sd62;
               prod = mag64 * 64'(acc_ff);
               y_ff     <= (prod + (64'd1 << (over - 64'sd1))) >> over;
               state_ff <= S_SAT;
            end
            // Restore the sign, saturate and pack with the gain
            S_SAT: begin
               res = y_ff;
               if (neg_ff) begin
                  if (res > (64'd1 << (SB - 1))) res = 64'd1 << (SB - 1);
                  res = -res;
               end else if (res > (64'd1 << (SB - 1)) - 1) begin
                  res = (64'd1 << (SB - 1)) - 1;
               end
               tot_tmp = -((64'(ng_ff) + 64'd32768) >> 16);
               y_ff     <= 64'({tot_tmp[14:0], res[SB-1:0]});
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!ov_ff) begin
                  out_ff   <= RSP_W'(y_ff);
                  ov_ff    <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire
